[src/sfr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stream find-and-replace unit.
// No dependencies; imported by the controller, datapath and top level.
package sfr_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int COUNT_BITS  = 16;
	localparam int BYTE_W      = 8;
	localparam int REG_W       = 64;
	localparam int LEN_W       = 4;
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int PTR_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SHOWN_W     = 16;

	typedef struct packed {
		logic [REG_W-1:0] match_bytes;
		logic [CNT_W-1:0] match_len;
		logic [REG_W-1:0] replace_bytes;
		logic [CNT_W-1:0] replace_len;
		logic             clear_pending;
	} sfr_cfg_t;

	typedef struct packed {
		logic load;
		logic drop;
		logic match;
		logic put_empty;
		logic emit;
		logic finish;
	} sfr_cmd_t;

	typedef struct packed {
		logic pend_empty;
		logic prefix;
		logic full_match;
		logic last;
		logic out_empty;
		logic emit_final;
		logic out_free;
	} sfr_status_t;

	function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		if (v > LEN_W'(MAX_PATTERN)) begin
			return CNT_W'(MAX_PATTERN);
		end
		return CNT_W'(v);
	endfunction

endpackage

[src/sfr_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the stream find-and-replace unit.
// Depends on sfr_pkg; drives datapath commands from its status.
module sfr_ctrl
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  sfr_status_t status,
	output sfr_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.pend_empty || status.prefix) begin
					cmd.match = status.full_match && !status.pend_empty;
					state_d   = status.last ? ST_FLUSH : ST_EMIT;
				end else begin
					cmd.drop = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!status.pend_empty) begin
					cmd.drop = 1'b1;
				end else begin
					cmd.put_empty = status.out_empty;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_empty) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.emit_final) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/sfr_datapath.sv]
`timescale 1ns / 1ps
// Pending buffer, prefix compare, result buffer and output register.
// Depends on sfr_pkg; commanded by sfr_ctrl.
module sfr_datapath
	import sfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_cfg_t          cfg,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  sfr_cmd_t          cmd,
	output sfr_status_t       status,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic [BYTE_W-1:0]     pend_q [MAX_PATTERN];
	logic [CNT_W-1:0]      pend_cnt_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [BYTE_W-1:0]     obuf_byte_q [MAX_PATTERN];
	logic                  obuf_vld_q [MAX_PATTERN];
	logic [CNT_W-1:0]      out_n_q;
	logic [CNT_W-1:0]      emit_idx_q;
	logic                  last_q;
	logic                  m_tvalid_q;
	logic [BYTE_W-1:0]     m_byte_q;
	logic                  m_user_q;
	logic                  m_last_q;
	logic [SHOWN_W-1:0]    m_count_q;
	logic                  prefix;
	logic                  emit_final;

	always_comb begin
		prefix = (pend_cnt_q <= cfg.match_len);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CNT_W'(i) < pend_cnt_q) &&
			    (pend_q[i] != cfg.match_bytes[BYTE_W*i +: BYTE_W])) begin
				prefix = 1'b0;
			end
		end
	end

	assign emit_final = (CNT_W'(emit_idx_q + 1'b1) == out_n_q);

	assign status.pend_empty = (pend_cnt_q == '0);
	assign status.prefix     = prefix;
	assign status.full_match = prefix && (pend_cnt_q == cfg.match_len);
	assign status.last       = last_q;
	assign status.out_empty  = (out_n_q == '0);
	assign status.emit_final = emit_final;
	assign status.out_free   = !m_tvalid_q || m_tready;

	// pending buffer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_q[pend_cnt_q[PTR_BITS-1:0]] <= in_byte;
		end else if (cmd.drop) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				pend_q[i] <= pend_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cfg.clear_pending) begin
				pend_cnt_q <= '0;
			end else if (cmd.load) begin
				pend_cnt_q <= CNT_W'(pend_cnt_q + 1'b1);
			end else if (cmd.drop) begin
				pend_cnt_q <= CNT_W'(pend_cnt_q - 1'b1);
			end else if (cmd.match || (cmd.finish && last_q)) begin
				pend_cnt_q <= '0;
			end
			if (cmd.load) begin
				last_q <= in_last;
			end
		end
	end

	// replacement count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.match) begin
			if (total_q != '1) begin
				total_q <= COUNT_BITS'(total_q + 1'b1);
			end
		end else if (cmd.finish && last_q) begin
			total_q <= '0;
		end
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (cmd.drop && (out_n_q < CNT_W'(MAX_PATTERN))) begin
			obuf_byte_q[out_n_q[PTR_BITS-1:0]] <= pend_q[0];
			obuf_vld_q[out_n_q[PTR_BITS-1:0]]  <= 1'b1;
		end else if (cmd.match) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				obuf_byte_q[i] <= cfg.replace_bytes[BYTE_W*i +: BYTE_W];
				obuf_vld_q[i]  <= 1'b1;
			end
		end else if (cmd.put_empty) begin
			obuf_byte_q[0] <= '0;
			obuf_vld_q[0]  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_n_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.load) begin
				out_n_q <= '0;
			end else if (cmd.drop && (out_n_q < CNT_W'(MAX_PATTERN))) begin
				out_n_q <= CNT_W'(out_n_q + 1'b1);
			end else if (cmd.match) begin
				out_n_q <= cfg.replace_len;
			end else if (cmd.put_empty) begin
				out_n_q <= CNT_W'(1);
			end
			if (cmd.load) begin
				emit_idx_q <= '0;
			end else if (cmd.emit) begin
				emit_idx_q <= CNT_W'(emit_idx_q + 1'b1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_byte_q  <= obuf_byte_q[emit_idx_q[PTR_BITS-1:0]];
			m_user_q  <= obuf_vld_q[emit_idx_q[PTR_BITS-1:0]];
			m_last_q  <= emit_final;
			m_count_q <= SHOWN_W'(total_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_count_q, m_byte_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

endmodule

[src/stream_find_replace_unit.sv]
`timescale 1ns / 1ps
// Stream find-and-replace unit: configuration registers, controller, datapath.
// Depends on sfr_pkg, sfr_ctrl and sfr_datapath.
// Sequence: the word is accepted in idle, scan drops pending bytes until the rest is a prefix,
// flush drops the remaining pending bytes on the last word, then the result words are emitted.
// Throughput: a new word is accepted only once the previous word's results are all emitted.
// Reset: arst_n clears registers, pending count and output valid asynchronously.
module stream_find_replace_unit
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // text_byte
	input  logic        s_tlast,  // text_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_byte, replace_count
	output logic        m_tlast,  // run_last
	output logic        m_tuser   // byte_valid
);

	localparam logic [1:0] REG_MATCH_BYTES   = 2'd0;
	localparam logic [1:0] REG_MATCH_LEN     = 2'd1;
	localparam logic [1:0] REG_REPLACE_BYTES = 2'd2;
	localparam logic [1:0] REG_REPLACE_LEN   = 2'd3;

	logic [REG_W-1:0] match_bytes_q;
	logic [LEN_W-1:0] match_len_q;
	logic [REG_W-1:0] replace_bytes_q;
	logic [LEN_W-1:0] replace_len_q;
	logic             wr_en;
	logic [1:0]       reg_idx;
	sfr_cfg_t         cfg;
	sfr_cmd_t         cmd;
	sfr_status_t      status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_bytes_q   <= '0;
			match_len_q     <= '0;
			replace_bytes_q <= '0;
			replace_len_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MATCH_BYTES:   match_bytes_q   <= pwdata;
				REG_MATCH_LEN:     match_len_q     <= pwdata[LEN_W-1:0];
				REG_REPLACE_BYTES: replace_bytes_q <= pwdata;
				REG_REPLACE_LEN:   replace_len_q   <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MATCH_BYTES:   prdata = match_bytes_q;
			REG_MATCH_LEN:     prdata = 64'(match_len_q);
			REG_REPLACE_BYTES: prdata = replace_bytes_q;
			REG_REPLACE_LEN:   prdata = 64'(replace_len_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.match_bytes   = match_bytes_q;
	assign cfg.match_len     = clamp_len(match_len_q);
	assign cfg.replace_bytes = replace_bytes_q;
	assign cfg.replace_len   = clamp_len(replace_len_q);
	assign cfg.clear_pending = wr_en &&
	                           ((reg_idx == REG_MATCH_BYTES) || (reg_idx == REG_MATCH_LEN));

	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sfr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
